FILE: rtl/sgd_latent_factor_update_top_defines.svh
// Assertion macros shared by the SGD update RTL.
// Used by the files that carry concurrent checks; no other dependencies.
`ifndef SGD_LATENT_FACTOR_UPDATE_TOP_DEFINES_SVH
`define SGD_LATENT_FACTOR_UPDATE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SGD_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sgd assertion failed");
`define SGD_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) (prop)) \
    else $error("sgd assertion failed");
`else
`define SGD_ASSERT(lbl, prop)
`define SGD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/sgd_pkg.sv
// Package for the SGD latent factor update block: widths, types, register codes.
// No dependencies.
`timescale 1ns / 1ps

package sgd_pkg;

    localparam int LATENT_SIZE = 3;
    localparam int NVEC        = 3;
    localparam int VEC_W       = 24;
    localparam int RATE_W      = 8;
    localparam int CNT_W       = 16;
    localparam int ERR_W       = 32;
    localparam int CFG_W       = 24;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int FRAC        = 20;
    localparam int STEP_FRAC   = 28;
    localparam int LAM_SHIFT   = 4;

    // step size path
    localparam int M_W          = CNT_W + 1;
    localparam int SQ_FRAC      = 32;
    localparam int SQ_X_W       = M_W + SQ_FRAC;
    localparam int SQ_R_W       = SQ_X_W + 1;
    localparam int SQ_Q_W       = (SQ_X_W + 1) / 2;
    localparam int SQRT_STAGES  = SQ_Q_W;
    localparam int P_W          = M_W + SQ_Q_W;
    localparam int P_SPLIT      = 21;
    localparam int PP_W         = CFG_W + P_SPLIT;
    localparam int TS_W         = CFG_W + P_W;
    localparam int T_W          = P_W;
    localparam int DEN_W        = T_W + 1;
    localparam int DEN_ONE_SHIFT = 16;
    localparam int NUM_SHIFT    = 19;
    localparam int NUM_W        = CFG_W + 2 + NUM_SHIFT;
    localparam int STEP_W       = 29;
    localparam int DIV_STAGES   = STEP_W;
    localparam int DIV_R_W      = DEN_W;
    localparam int DLY_STAGES   = SQRT_STAGES + DIV_STAGES + 3;

    // gradient path
    localparam int PROD_W  = 2 * VEC_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int E40_W   = DOT_W + 1;
    localparam int EB_W    = ERR_W + VEC_W;
    localparam int LV_W    = CFG_W + 1 + VEC_W;
    localparam int G_W     = EB_W + 1;
    localparam int G20_W   = G_W - FRAC;
    localparam int GLO_W   = 18;
    localparam int GHI_W   = G20_W - GLO_W;
    localparam int PLO_W   = STEP_W + GLO_W;
    localparam int PHI_W   = STEP_W + 1 + GHI_W;
    localparam int FULL_W  = PHI_W + GLO_W;
    localparam int DELTA_W = FULL_W - STEP_FRAC;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int GRAD_STAGES = 7;

    localparam logic [CFG_W-1:0] LR_RESET     = 24'd16777;
    localparam logic [CFG_W-1:0] DECAY_RESET  = 24'd15099494;
    localparam logic [CFG_W-1:0] LAMBDA_RESET = 24'd16777;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef vec_t [NVEC-1:0] vec_arr_t;

    typedef struct packed {
        vec_arr_t          a;
        vec_arr_t          b;
        logic [RATE_W-1:0] rating;
    } item_t;

    typedef struct packed {
        vec_arr_t                 new_a;
        vec_arr_t                 new_b;
        logic signed [ERR_W-1:0]  err;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] lr;
        logic [CFG_W-1:0] decay;
        logic [CFG_W-1:0] lambda;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_LR     = 2'd0,
        REG_DECAY  = 2'd1,
        REG_LAMBDA = 2'd2
    } reg_idx_t;

endpackage

FILE: rtl/sgd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on sgd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sgd_latent_factor_update_top_defines.svh"

module sgd_sqrt import sgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [M_W-1:0]    in_m,
    output logic              out_valid,
    output logic [M_W-1:0]    out_m,
    output logic [SQ_Q_W-1:0] out_q
);

    logic              valid_reg [SQRT_STAGES];
    logic [M_W-1:0]    m_reg     [SQRT_STAGES];
    logic [SQ_X_W-1:0] x_reg     [SQRT_STAGES];
    logic [SQ_X_W-1:0] x_next    [SQRT_STAGES];
    logic [SQ_R_W-1:0] r_reg     [SQRT_STAGES];
    logic [SQ_R_W-1:0] r_next    [SQRT_STAGES];

    always_comb
    begin
        logic [SQ_X_W-1:0] x_in;
        logic [SQ_R_W-1:0] r_in;
        logic [SQ_R_W-1:0] bitv;
        logic [SQ_R_W-1:0] trial;
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (s == 0)
            begin
                x_in = {in_m, {SQ_FRAC{1'b0}}};
                r_in = '0;
            end
            else
            begin
                x_in = x_reg[s-1];
                r_in = r_reg[s-1];
            end
            bitv  = SQ_R_W'(1) << (2 * (SQRT_STAGES - 1 - s));
            trial = r_in + bitv;
            if ({1'b0, x_in} >= trial)
            begin
                x_next[s] = x_in - trial[SQ_X_W-1:0];
                r_next[s] = (r_in >> 1) + bitv;
            end
            else
            begin
                x_next[s] = x_in;
                r_next[s] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= in_m;
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            m_reg[s] <= m_reg[s-1];
        end
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            x_reg[s] <= x_next[s];
            r_reg[s] <= r_next[s];
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_m     = m_reg[SQRT_STAGES-1];
    assign out_q     = r_reg[SQRT_STAGES-1][SQ_Q_W-1:0];

    `SGD_ASSERT(a_root_fits, out_valid |-> (r_reg[SQRT_STAGES-1][SQ_R_W-1:SQ_Q_W] == '0))
    `SGD_ASSERT(a_rem_fits, out_valid |-> ({1'b0, x_reg[SQRT_STAGES-1]} <= {r_reg[SQRT_STAGES-1], 1'b0}))

endmodule

FILE: rtl/sgd_div.sv
// Pipelined restoring divider for the step size, one quotient bit per stage.
// Depends on sgd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sgd_latent_factor_update_top_defines.svh"

module sgd_div import sgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    output logic              out_valid,
    output logic [STEP_W-1:0] out_q
);

    logic               valid_reg [DIV_STAGES];
    logic [DIV_R_W-1:0] rem_reg   [DIV_STAGES];
    logic [DIV_R_W-1:0] rem_next  [DIV_STAGES];
    logic [STEP_W-1:0]  low_reg   [DIV_STAGES];
    logic [STEP_W-1:0]  low_next  [DIV_STAGES];
    logic [STEP_W-1:0]  q_reg     [DIV_STAGES];
    logic [STEP_W-1:0]  q_next    [DIV_STAGES];
    logic [DEN_W-1:0]   den_reg   [DIV_STAGES];

    always_comb
    begin
        logic [DIV_R_W-1:0] rem_in;
        logic [STEP_W-1:0]  low_in;
        logic [STEP_W-1:0]  q_in;
        logic [DEN_W-1:0]   den_in;
        logic [DIV_R_W:0]   shifted;
        logic [DIV_R_W:0]   diff;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_in = DIV_R_W'(in_num[NUM_W-1:STEP_W]);
                low_in = in_num[STEP_W-1:0];
                q_in   = '0;
                den_in = in_den;
            end
            else
            begin
                rem_in = rem_reg[s-1];
                low_in = low_reg[s-1];
                q_in   = q_reg[s-1];
                den_in = den_reg[s-1];
            end
            shifted     = {rem_in, low_in[STEP_W-1]};
            diff        = shifted - {1'b0, den_in};
            low_next[s] = {low_in[STEP_W-2:0], 1'b0};
            if (shifted >= {1'b0, den_in})
            begin
                rem_next[s] = diff[DIV_R_W-1:0];
                q_next[s]   = {q_in[STEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = shifted[DIV_R_W-1:0];
                q_next[s]   = {q_in[STEP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= in_den;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            den_reg[s] <= den_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            low_reg[s] <= low_next[s];
            q_reg[s]   <= q_next[s];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];

    `SGD_ASSERT(a_rem_below_den, out_valid |-> (rem_reg[DIV_STAGES-1] < den_reg[DIV_STAGES-1]))
    `SGD_ASSERT(a_low_drained, out_valid |-> (low_reg[DIV_STAGES-1] == '0))

endmodule

FILE: rtl/sgd_grad.sv
// Error, regularized gradient and saturating update pipeline (seven stages).
// Depends on sgd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sgd_latent_factor_update_top_defines.svh"

module sgd_grad import sgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  item_t             in_item,
    input  logic [STEP_W-1:0] in_step,
    input  cfg_t              cfg,
    output logic              out_valid,
    output result_t           out_result
);

    function automatic vec_t sat_vec(input logic signed [SUM_W-1:0] x);
        if (x > SUM_W'((2 ** (VEC_W - 1)) - 1))
            sat_vec = {1'b0, {(VEC_W-1){1'b1}}};
        else if (x < -SUM_W'(2 ** (VEC_W - 1)))
            sat_vec = {1'b1, {(VEC_W-1){1'b0}}};
        else
            sat_vec = x[VEC_W-1:0];
    endfunction

    logic [GRAD_STAGES-1:0] v_reg;

    // stage 1
    vec_arr_t                 a1_reg, b1_reg;
    logic [RATE_W-1:0]        r1_reg;
    logic [STEP_W-1:0]        step1_reg;
    logic signed [PROD_W-1:0] prod1_reg [NVEC];
    // stage 2
    vec_arr_t                 a2_reg, b2_reg;
    logic [RATE_W-1:0]        r2_reg;
    logic [STEP_W-1:0]        step2_reg;
    logic signed [DOT_W-1:0]  dot2_reg;
    // stage 3
    vec_arr_t                 a3_reg, b3_reg;
    logic [STEP_W-1:0]        step3_reg;
    logic signed [ERR_W-1:0]  e3_reg;
    // stage 4
    vec_arr_t                 a4_reg, b4_reg;
    logic [STEP_W-1:0]        step4_reg;
    logic signed [ERR_W-1:0]  e4_reg;
    logic signed [EB_W-1:0]   eb4_reg [NVEC];
    logic signed [EB_W-1:0]   ea4_reg [NVEC];
    logic signed [LV_W-1:0]   la4_reg [NVEC];
    logic signed [LV_W-1:0]   lb4_reg [NVEC];
    // stage 5
    vec_arr_t                 a5_reg, b5_reg;
    logic [STEP_W-1:0]        step5_reg;
    logic signed [ERR_W-1:0]  e5_reg;
    logic signed [G20_W-1:0]  ga5_reg [NVEC];
    logic signed [G20_W-1:0]  gb5_reg [NVEC];
    // stage 6
    vec_arr_t                 a6_reg, b6_reg;
    logic signed [ERR_W-1:0]  e6_reg;
    logic [PLO_W-1:0]         pal6_reg [NVEC];
    logic [PLO_W-1:0]         pbl6_reg [NVEC];
    logic signed [PHI_W-1:0]  pah6_reg [NVEC];
    logic signed [PHI_W-1:0]  pbh6_reg [NVEC];
    // stage 7
    result_t                  res_reg;

    logic signed [DOT_W-1:0]  dot_next;
    logic signed [ERR_W-1:0]  e_next;
    logic signed [G20_W-1:0]  ga_next [NVEC];
    logic signed [G20_W-1:0]  gb_next [NVEC];
    result_t                  res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[GRAD_STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        dot_next = '0;
        for (int i = 0; i < NVEC; i++)
        begin
            dot_next = dot_next + DOT_W'(prod1_reg[i]);
        end
    end

    always_comb
    begin
        logic signed [E40_W-1:0] err40;
        err40 = $signed({{(E40_W-RATE_W-2*FRAC){1'b0}}, r2_reg, {(2*FRAC){1'b0}}})
              - E40_W'(dot2_reg) + (E40_W'(1) <<< (FRAC - 1));
        // rounded error stays well inside 32 bits, so truncating it to ERR_W loses nothing
        e_next = ERR_W'(err40 >>> FRAC);
    end

    always_comb
    begin
        logic signed [G_W-1:0] ga;
        logic signed [G_W-1:0] gb;
        for (int i = 0; i < NVEC; i++)
        begin
            ga = G_W'(eb4_reg[i]) - G_W'(la4_reg[i] >>> LAM_SHIFT) + (G_W'(1) <<< (FRAC - 1));
            gb = G_W'(ea4_reg[i]) - G_W'(lb4_reg[i] >>> LAM_SHIFT) + (G_W'(1) <<< (FRAC - 1));
            ga_next[i] = G20_W'(ga >>> FRAC);
            gb_next[i] = G20_W'(gb >>> FRAC);
        end
    end

    always_comb
    begin
        logic signed [FULL_W-1:0]  hi_ext;
        logic signed [FULL_W-1:0]  lo_ext;
        logic signed [FULL_W-1:0]  full;
        logic signed [DELTA_W-1:0] delta;
        logic signed [SUM_W-1:0]   sum;
        res_next.err = e6_reg;
        for (int i = 0; i < NVEC; i++)
        begin
            hi_ext = pah6_reg[i];
            lo_ext = $signed({{(FULL_W-PLO_W){1'b0}}, pal6_reg[i]});
            full   = (hi_ext <<< GLO_W) + lo_ext + (FULL_W'(1) <<< (STEP_FRAC - 1));
            delta  = DELTA_W'(full >>> STEP_FRAC);
            sum    = SUM_W'($signed(a6_reg[i])) + SUM_W'(delta);
            res_next.new_a[i] = (i < LATENT_SIZE) ? sat_vec(sum) : '0;

            hi_ext = pbh6_reg[i];
            lo_ext = $signed({{(FULL_W-PLO_W){1'b0}}, pbl6_reg[i]});
            full   = (hi_ext <<< GLO_W) + lo_ext + (FULL_W'(1) <<< (STEP_FRAC - 1));
            delta  = DELTA_W'(full >>> STEP_FRAC);
            sum    = SUM_W'($signed(b6_reg[i])) + SUM_W'(delta);
            res_next.new_b[i] = (i < LATENT_SIZE) ? sat_vec(sum) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= in_item.a;
        b1_reg    <= in_item.b;
        r1_reg    <= in_item.rating;
        step1_reg <= in_step;
        for (int i = 0; i < NVEC; i++)
        begin
            if (i < LATENT_SIZE)
                prod1_reg[i] <= $signed(in_item.a[i]) * $signed(in_item.b[i]);
            else
                prod1_reg[i] <= '0;
        end

        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        r2_reg    <= r1_reg;
        step2_reg <= step1_reg;
        dot2_reg  <= dot_next;

        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        step3_reg <= step2_reg;
        e3_reg    <= e_next;

        a4_reg    <= a3_reg;
        b4_reg    <= b3_reg;
        step4_reg <= step3_reg;
        e4_reg    <= e3_reg;
        for (int i = 0; i < NVEC; i++)
        begin
            eb4_reg[i] <= e3_reg * $signed(b3_reg[i]);
            ea4_reg[i] <= e3_reg * $signed(a3_reg[i]);
            la4_reg[i] <= $signed({1'b0, cfg.lambda}) * $signed(a3_reg[i]);
            lb4_reg[i] <= $signed({1'b0, cfg.lambda}) * $signed(b3_reg[i]);
        end

        a5_reg    <= a4_reg;
        b5_reg    <= b4_reg;
        step5_reg <= step4_reg;
        e5_reg    <= e4_reg;
        for (int i = 0; i < NVEC; i++)
        begin
            ga5_reg[i] <= ga_next[i];
            gb5_reg[i] <= gb_next[i];
        end

        a6_reg <= a5_reg;
        b6_reg <= b5_reg;
        e6_reg <= e5_reg;
        for (int i = 0; i < NVEC; i++)
        begin
            pal6_reg[i] <= step5_reg * ga5_reg[i][GLO_W-1:0];
            pbl6_reg[i] <= step5_reg * gb5_reg[i][GLO_W-1:0];
            pah6_reg[i] <= $signed({1'b0, step5_reg}) * $signed(ga5_reg[i][G20_W-1:GLO_W]);
            pbh6_reg[i] <= $signed({1'b0, step5_reg}) * $signed(gb5_reg[i][G20_W-1:GLO_W]);
        end

        res_reg <= res_next;
    end

    assign out_valid  = v_reg[GRAD_STAGES-1];
    assign out_result = res_reg;

    `SGD_ASSERT(a_grad_latency, in_valid |-> ##GRAD_STAGES out_valid)
    `SGD_ASSERT(a_err_carried, v_reg[GRAD_STAGES-2] |=> (out_result.err == $past(e6_reg)))

endmodule

FILE: rtl/sgd_latent_factor_update_top.sv
// SGD latent factor update: one rating in, updated item/user vectors and error out.
// Throughput: one item per cycle.
// Depth is set by the 25-stage square root and the 29-stage step size divider, followed by the gradient pipeline.
// busy is never asserted; the result strobe cannot be held off by the receiver.
// Reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
`include "sgd_latent_factor_update_top_defines.svh"

module sgd_latent_factor_update_top import sgd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VEC_W-1:0] item_vec_0,
    input  logic signed [VEC_W-1:0] item_vec_1,
    input  logic signed [VEC_W-1:0] item_vec_2,
    input  logic signed [VEC_W-1:0] user_vec_0,
    input  logic signed [VEC_W-1:0] user_vec_1,
    input  logic signed [VEC_W-1:0] user_vec_2,
    input  logic [RATE_W-1:0]       rating,
    input  logic [CNT_W-1:0]        update_count,
    output logic                    done,
    output logic signed [VEC_W-1:0] new_item_0,
    output logic signed [VEC_W-1:0] new_item_1,
    output logic signed [VEC_W-1:0] new_item_2,
    output logic signed [VEC_W-1:0] new_user_0,
    output logic signed [VEC_W-1:0] new_user_1,
    output logic signed [VEC_W-1:0] new_user_2,
    output logic signed [ERR_W-1:0] pred_error
);

    cfg_t              cfg_reg;
    logic              s0_valid_reg;
    item_t             s0_item_reg;
    logic [CNT_W-1:0]  s0_cnt_reg;

    logic              sq_valid;
    logic [M_W-1:0]    sq_m;
    logic [SQ_Q_W-1:0] sq_q;

    logic              p_valid_reg;
    logic [P_W-1:0]    p_reg;
    logic              pp_valid_reg;
    logic [PP_W-1:0]   pl_reg;
    logic [PP_W-1:0]   ph_reg;
    logic              den_valid_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [TS_W-1:0]   t_sum;

    logic              step_valid;
    logic [STEP_W-1:0] step;

    logic              dly_valid_reg [DLY_STAGES];
    item_t             dly_item_reg  [DLY_STAGES];

    logic              res_valid;
    result_t           res;
    item_t             in_item;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lr     <= LR_RESET;
            cfg_reg.decay  <= DECAY_RESET;
            cfg_reg.lambda <= LAMBDA_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
                REG_LR:     cfg_reg.lr     <= pwdata[CFG_W-1:0];
                REG_DECAY:  cfg_reg.decay  <= pwdata[CFG_W-1:0];
                REG_LAMBDA: cfg_reg.lambda <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_LR:     prdata = DATA_W'(cfg_reg.lr);
            REG_DECAY:  prdata = DATA_W'(cfg_reg.decay);
            REG_LAMBDA: prdata = DATA_W'(cfg_reg.lambda);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        in_item.a      = {item_vec_2, item_vec_1, item_vec_0};
        in_item.b      = {user_vec_2, user_vec_1, user_vec_0};
        in_item.rating = rating;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            p_valid_reg   <= 1'b0;
            pp_valid_reg  <= 1'b0;
            den_valid_reg <= 1'b0;
            for (int k = 0; k < DLY_STAGES; k++)
            begin
                dly_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s0_valid_reg     <= start && !busy;
            p_valid_reg      <= sq_valid;
            pp_valid_reg     <= p_valid_reg;
            den_valid_reg    <= pp_valid_reg;
            dly_valid_reg[0] <= s0_valid_reg;
            for (int k = 1; k < DLY_STAGES; k++)
            begin
                dly_valid_reg[k] <= dly_valid_reg[k-1];
            end
        end
    end

    assign t_sum = (TS_W'(ph_reg) << P_SPLIT) + TS_W'(pl_reg);

    always_ff @(posedge clk)
    begin
        s0_item_reg <= in_item;
        s0_cnt_reg  <= update_count;
        p_reg       <= P_W'(sq_m) * P_W'(sq_q);
        pl_reg      <= PP_W'(cfg_reg.decay) * PP_W'(p_reg[P_SPLIT-1:0]);
        ph_reg      <= PP_W'(cfg_reg.decay) * PP_W'(p_reg[P_W-1:P_SPLIT]);
        den_reg     <= DEN_W'(t_sum[TS_W-1:CFG_W]) + (DEN_W'(1) << DEN_ONE_SHIFT);
        num_reg     <= (NUM_W'({cfg_reg.lr, 1'b0}) + NUM_W'(cfg_reg.lr)) << NUM_SHIFT;
        dly_item_reg[0] <= s0_item_reg;
        for (int k = 1; k < DLY_STAGES; k++)
        begin
            dly_item_reg[k] <= dly_item_reg[k-1];
        end
    end

    sgd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_m      (M_W'(s0_cnt_reg) + M_W'(1)),
        .out_valid (sq_valid),
        .out_m     (sq_m),
        .out_q     (sq_q)
    );

    sgd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (den_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (step_valid),
        .out_q     (step)
    );

    sgd_grad u_grad (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dly_valid_reg[DLY_STAGES-1]),
        .in_item    (dly_item_reg[DLY_STAGES-1]),
        .in_step    (step),
        .cfg        (cfg_reg),
        .out_valid  (res_valid),
        .out_result (res)
    );

    assign done       = res_valid;
    assign new_item_0 = res.new_a[0];
    assign new_item_1 = res.new_a[1];
    assign new_item_2 = res.new_a[2];
    assign new_user_0 = res.new_b[0];
    assign new_user_1 = res.new_b[1];
    assign new_user_2 = res.new_b[2];
    assign pred_error = res.err;

    `SGD_ASSERT(a_step_align, step_valid == dly_valid_reg[DLY_STAGES-1])
    `SGD_ASSERT(a_den_floor, den_valid_reg |-> (den_reg >= (DEN_W'(1) << DEN_ONE_SHIFT)))
    `SGD_ASSERT_ALWAYS(a_no_backpressure, !busy)

endmodule

FILE: verif/sgd_latent_factor_update_top_tb.sv
// Self-checking testbench for sgd_latent_factor_update_top: APB register setup,
// directed and random rating updates with and without idle gaps, scoreboard with a fixed-point predictor.
// Depends on sgd_pkg and the RTL of sgd_latent_factor_update_top.
`timescale 1ns / 1ps

module sgd_latent_factor_update_top_tb;
    import sgd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam longint VMAX = 64'sd8388607;
    localparam longint VMIN = -64'sd8388608;
    localparam longint EMAX = 64'sd2147483647;
    localparam longint EMIN = -64'sd2147483648;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 4'd12;

    typedef struct {
        vec_arr_t          a;
        vec_arr_t          b;
        logic [RATE_W-1:0] rating;
        logic [CNT_W-1:0]  count;
    } rating_upd_t;

    class update_scoreboard;
        result_t   pending_q[$];
        int        errors;
        bit [63:0] lr, decay, lambda;

        function new();
            errors = 0;
            lr     = LR_RESET;
            decay  = DECAY_RESET;
            lambda = LAMBDA_RESET;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_LR:     lr     = val[CFG_W-1:0];
                REG_DECAY:  decay  = val[CFG_W-1:0];
                REG_LAMBDA: lambda = val[CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint rnd(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint sat(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        function bit [63:0] isqrt(bit [63:0] x);
            bit [63:0] r, bt;
            r  = 0;
            bt = 64'd1 << 62;
            while (bt > x)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (x >= r + bt)
                begin
                    x = x - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r = r >> 1;
                bt = bt >> 2;
            end
            return r;
        endfunction

        function result_t sgd_step(rating_upd_t u);
            result_t   res;
            longint    a[NVEC], b[NVEC];
            longint    dot, err40, e20, g, stp, lam;
            bit [63:0] m, q, p, t, den;
            dot = 0;
            for (int i = 0; i < NVEC; i++)
            begin
                a[i] = longint'($signed(u.a[i]));
                b[i] = longint'($signed(u.b[i]));
                if (i < LATENT_SIZE)
                    dot += a[i] * b[i];
            end
            err40 = (longint'(u.rating) <<< 40) - dot;
            e20   = sat(rnd(err40, 20), EMIN, EMAX);
            m   = 64'(u.count) + 64'd1;
            q   = isqrt(m << 32);
            p   = m * q;
            t   = (decay * p) >> 24;
            den = (64'd1 << 16) + t;
            stp = longint'(((64'd3 * lr) << 19) / den);
            lam = longint'(lambda);
            for (int i = 0; i < NVEC; i++)
            begin
                if (i < LATENT_SIZE)
                begin
                    g = rnd(e20 * b[i] - ((lam * a[i]) >>> 4), 20);
                    res.new_a[i] = VEC_W'(sat(a[i] + rnd(stp * g, 28), VMIN, VMAX));
                    g = rnd(e20 * a[i] - ((lam * b[i]) >>> 4), 20);
                    res.new_b[i] = VEC_W'(sat(b[i] + rnd(stp * g, 28), VMIN, VMAX));
                end
                else
                begin
                    res.new_a[i] = '0;
                    res.new_b[i] = '0;
                end
            end
            res.err = ERR_W'(e20);
            return res;
        endfunction

        function void note_input(rating_upd_t u);
            pending_q.push_back(sgd_step(u));
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            for (int i = 0; i < NVEC; i++)
            begin
                if (got.new_a[i] !== exp_r.new_a[i])
                begin
                    $display("%0t: new_item_%0d expected %h actual %h", $time, i,
                             exp_r.new_a[i], got.new_a[i]);
                    errors++;
                end
                if (got.new_b[i] !== exp_r.new_b[i])
                begin
                    $display("%0t: new_user_%0d expected %h actual %h", $time, i,
                             exp_r.new_b[i], got.new_b[i]);
                    errors++;
                end
            end
            if (got.err !== exp_r.err)
            begin
                $display("%0t: pred_error expected %h actual %h", $time, exp_r.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic start, busy, done;
    logic signed [VEC_W-1:0] item_vec_0, item_vec_1, item_vec_2;
    logic signed [VEC_W-1:0] user_vec_0, user_vec_1, user_vec_2;
    logic [RATE_W-1:0] rating;
    logic [CNT_W-1:0]  update_count;
    logic signed [VEC_W-1:0] new_item_0, new_item_1, new_item_2;
    logic signed [VEC_W-1:0] new_user_0, new_user_1, new_user_2;
    logic signed [ERR_W-1:0] pred_error;

    update_scoreboard sb = new();
    bit idle_en;
    int cycles;

    sgd_latent_factor_update_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rating_upd_t u;
        result_t     r;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && start && !busy)
        begin
            u.a = '{item_vec_2, item_vec_1, item_vec_0};
            u.b = '{user_vec_2, user_vec_1, user_vec_0};
            u.rating = rating;
            u.count  = update_count;
            sb.note_input(u);
        end
        if (rst_n && done)
        begin
            r.new_a = '{new_item_2, new_item_1, new_item_0};
            r.new_b = '{new_user_2, new_user_1, new_user_0};
            r.err   = pred_error;
            sb.check_result(r);
        end
    end

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr < 4'd12)
            sb.set_reg(reg_idx_t'(addr >> 2), val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_cfg(logic [CFG_W-1:0] lr_v, logic [CFG_W-1:0] dec_v,
                           logic [CFG_W-1:0] lam_v);
        reg_write(4'(REG_LR) << 2, DATA_W'(lr_v));
        reg_write(4'(REG_DECAY) << 2, DATA_W'(dec_v));
        reg_write(4'(REG_LAMBDA) << 2, DATA_W'(lam_v));
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_update(rating_upd_t u);
        while (idle_en && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        item_vec_0   <= u.a[0];
        item_vec_1   <= u.a[1];
        item_vec_2   <= u.a[2];
        user_vec_0   <= u.b[0];
        user_vec_1   <= u.b[1];
        user_vec_2   <= u.b[2];
        rating       <= u.rating;
        update_count <= u.count;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // called at a falling edge
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic vec_t rand_vec();
        if ($urandom_range(1))
            return vec_t'($urandom);
        return vec_t'($signed(22'($urandom)));
    endfunction

    task automatic send_random(int n);
        rating_upd_t u;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < NVEC; i++)
            begin
                u.a[i] = rand_vec();
                u.b[i] = rand_vec();
            end
            u.rating = RATE_W'($urandom);
            u.count  = $urandom_range(1) ? CNT_W'($urandom_range(100)) : CNT_W'($urandom);
            send_update(u);
        end
    endtask

    task automatic send_directed();
        rating_upd_t u;
        vec_t vals[5];
        vals = '{24'sh7FFFFF, -24'sh800000, 24'sh000000, 24'sh100000, -24'sh100000};
        for (int k = 0; k < 20; k++)
        begin
            for (int i = 0; i < NVEC; i++)
            begin
                u.a[i] = vals[(k + i) % 5];
                u.b[i] = vals[(k / 5 + 2 * i) % 5];
            end
            u.rating = (k % 2) ? 8'd255 : 8'd0;
            u.count  = (k % 3 == 0) ? 16'hFFFF : ((k % 3 == 1) ? 16'd0 : 16'd7);
            send_update(u);
        end
    endtask

    initial
    begin
        cycles = 0;
        idle_en = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0;
        item_vec_0 = '0; item_vec_1 = '0; item_vec_2 = '0;
        user_vec_0 = '0; user_vec_1 = '0; user_vec_2 = '0;
        rating = '0; update_count = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        send_random(60);
        drain();

        set_cfg(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        send_directed();
        idle_en = 1'b0;
        send_random(150);
        idle_en = 1'b1;
        drain();

        set_cfg(24'h000000, 24'hFFFFFF, 24'h000000);
        send_directed();
        send_random(120);
        drain();

        reg_write(ADDR_UNUSED, $urandom);
        reg_write(4'(REG_LR) << 2, 32'hFF00_1234 | DATA_W'($urandom_range(255)));
        reg_write(4'(REG_LAMBDA) << 2, 32'hA5FF_FFFF);
        send_random(140);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            set_cfg(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            send_random(140);
            drain();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
